/* src/msa_rle_pkg.sv */
// Shared types and constants for the MSA disk-image run-length decoder.
package msa_rle_pkg;

    // One input word: a byte of the image file and its end-of-file flag.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_file;
    } t_in_word;

    // One output word: a byte run or the final status report.
    typedef struct packed {
        logic        kind;
        logic [7:0]  run_value;
        logic [15:0] run_length;
        logic [23:0] dest_offset;
        logic [1:0]  status;
        logic        last_result;
    } t_out_word;

    // Parse phase of the file.
    typedef enum logic [2:0] {
        PH_HEADER = 3'd0,
        PH_LEN_HI = 3'd1,
        PH_LEN_LO = 3'd2,
        PH_DATA   = 3'd3,
        PH_DONE   = 3'd4,
        PH_ERROR  = 3'd5
    } t_phase;

    // Progress through a fill marker.
    typedef enum logic [1:0] {
        MK_IDLE = 2'd0,
        MK_FILL = 2'd1,
        MK_HI   = 2'd2,
        MK_LO   = 2'd3
    } t_marker;

    // Controller states.
    typedef enum logic [1:0] {
        CS_IDLE  = 2'd0,
        CS_MUL1  = 2'd1,
        CS_MUL2  = 2'd2,
        CS_CHECK = 2'd3
    } t_ctl_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_byte;
        logic mul_first;
        logic mul_second;
        logic check;
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic slot_free;
        logic hdr_check;
    } t_ctl_status;

    localparam logic [15:0] MAGIC_WORD     = 16'h0E0F;
    localparam logic [7:0]  RUN_MARK       = 8'hE5;
    localparam int          SECTOR_SHIFT   = 9;
    localparam logic [3:0]  HEADER_LEN     = 4'd10;
    localparam logic [23:0] CAPACITY_RESET = 24'd1474560;

    localparam logic KIND_RUN    = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_TOO_LARGE  = 2'd2;
    localparam logic [1:0] ST_TRUNCATED  = 2'd3;

endpackage

/* src/msa_rle_ctrl.sv */
// Controller state machine of the MSA run-length decoder.
module msa_rle_ctrl (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  msa_rle_pkg::t_ctl_status i_status,
    output msa_rle_pkg::t_ctl_cmd    o_cmd,
    output logic                     o_in_ready
);

    msa_rle_pkg::t_ctl_state r_state;
    msa_rle_pkg::t_ctl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msa_rle_pkg::CS_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            msa_rle_pkg::CS_IDLE: begin
                o_in_ready = i_status.slot_free;
                if (i_in_valid && i_status.slot_free) begin
                    o_cmd.take_byte = 1'b1;
                    // The last header byte starts the image size check.
                    if (i_status.hdr_check) begin
                        n_state = msa_rle_pkg::CS_MUL1;
                    end
                end
            end
            msa_rle_pkg::CS_MUL1: begin
                o_cmd.mul_first = 1'b1;
                n_state         = msa_rle_pkg::CS_MUL2;
            end
            msa_rle_pkg::CS_MUL2: begin
                o_cmd.mul_second = 1'b1;
                n_state          = msa_rle_pkg::CS_CHECK;
            end
            msa_rle_pkg::CS_CHECK: begin
                // Wait for room, as the check may report a status word.
                if (i_status.slot_free) begin
                    o_cmd.check = 1'b1;
                    n_state     = msa_rle_pkg::CS_IDLE;
                end
            end
            default: begin
                n_state = msa_rle_pkg::CS_IDLE;
            end
        endcase
    end

endmodule

/* src/msa_rle_datapath.sv */
// Datapath of the MSA run-length decoder: parse state, size check and output words.
module msa_rle_datapath #(
    parameter int OFFSET_BITS = 24
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  msa_rle_pkg::t_ctl_cmd    i_cmd,
    output msa_rle_pkg::t_ctl_status o_status,
    input  msa_rle_pkg::t_in_word    i_in_data,
    input  logic [23:0]              i_capacity,
    input  logic                     i_out_stall,
    output logic                     o_out_valid,
    output msa_rle_pkg::t_out_word   o_out_data
);

    localparam int NEED_BITS = 50 + msa_rle_pkg::SECTOR_SHIFT;

    msa_rle_pkg::t_phase  r_phase, n_phase;
    msa_rle_pkg::t_marker r_marker, n_marker;
    logic [3:0]             r_header_count, n_header_count;
    logic [15:0]            r_spt, n_spt;
    logic [16:0]            r_side_count, n_side_count;
    logic [15:0]            r_first, n_first;
    logic [15:0]            r_last, n_last;
    logic [15:0]            r_track_counter, n_track_counter;
    logic [16:0]            r_side_counter, n_side_counter;
    logic [15:0]            r_segment_left, n_segment_left;
    logic [24:0]            r_track_bytes, n_track_bytes;
    logic                   r_raw_track, n_raw_track;
    logic [24:0]            r_track_written, n_track_written;
    logic [OFFSET_BITS-1:0] r_track_base, n_track_base;
    logic [7:0]             r_held_fill, n_held_fill;
    logic [7:0]             r_held_hi, n_held_hi;
    logic [1:0]             r_error_code, n_error_code;
    logic                   r_eof_held, n_eof_held;
    logic [33:0]            r_mul_a, n_mul_a;
    logic [49:0]            r_prod, n_prod;
    logic                   r_out_valid, n_out_valid;
    logic                   r_pend_valid, n_pend_valid;
    msa_rle_pkg::t_out_word r_out_data, n_out_data;
    msa_rle_pkg::t_out_word r_pend_data, n_pend_data;

    msa_rle_pkg::t_out_word res0, res1;
    logic [1:0]             res_count;
    logic                   hdr_check;
    logic                   slot_free;
    logic                   taken;

    logic [OFFSET_BITS+24:0] tw_ext;
    logic [OFFSET_BITS+24:0] tb_ext;
    logic [OFFSET_BITS-1:0]  off_full;
    logic [OFFSET_BITS-1:0]  base_step;
    logic [OFFSET_BITS+23:0] off_ext;
    logic [OFFSET_BITS+23:0] size_ext;
    logic [16:0]             tracks;
    logic [NEED_BITS-1:0]    needed;
    logic                    too_large;

    assign tw_ext    = {{OFFSET_BITS{1'b0}}, r_track_written};
    assign tb_ext    = {{OFFSET_BITS{1'b0}}, r_track_bytes};
    assign off_full  = r_track_base + tw_ext[OFFSET_BITS-1:0];
    assign base_step = r_track_base + tb_ext[OFFSET_BITS-1:0];
    assign off_ext   = {24'd0, off_full};
    assign tracks    = {1'b0, r_last} - {1'b0, r_first} + 17'd1;
    assign needed    = {r_prod, {msa_rle_pkg::SECTOR_SHIFT{1'b0}}};
    assign too_large = (needed > {{(NEED_BITS-24){1'b0}}, i_capacity})
                    || (needed[NEED_BITS-1:OFFSET_BITS] != '0);

    assign taken     = r_out_valid && !i_out_stall;
    assign slot_free = !r_pend_valid && (!r_out_valid || !i_out_stall);

    assign o_status.slot_free = slot_free;
    assign o_status.hdr_check = hdr_check;
    assign o_out_valid        = r_out_valid;
    assign o_out_data         = r_out_data;

    always_comb begin
        logic [7:0]  b;
        logic        do_next;
        logic        do_eof;
        logic [15:0] cnt;
        logic [24:0] room;
        logic [1:0]  st;

        b        = i_in_data.in_byte;
        do_next  = 1'b0;
        do_eof   = 1'b0;
        cnt      = '0;
        room     = '0;
        st       = msa_rle_pkg::ST_OK;
        size_ext = '0;

        n_phase         = r_phase;
        n_marker        = r_marker;
        n_header_count  = r_header_count;
        n_spt           = r_spt;
        n_side_count    = r_side_count;
        n_first         = r_first;
        n_last          = r_last;
        n_track_counter = r_track_counter;
        n_side_counter  = r_side_counter;
        n_segment_left  = r_segment_left;
        n_track_bytes   = r_track_bytes;
        n_raw_track     = r_raw_track;
        n_track_written = r_track_written;
        n_track_base    = r_track_base;
        n_held_fill     = r_held_fill;
        n_held_hi       = r_held_hi;
        n_error_code    = r_error_code;
        n_eof_held      = r_eof_held;
        n_mul_a         = r_mul_a;
        n_prod          = r_prod;

        res0      = '0;
        res1      = '0;
        res_count = 2'd0;
        hdr_check = 1'b0;

        // Run word template: offset is where the next byte of the track lands.
        res0.kind        = msa_rle_pkg::KIND_RUN;
        res0.dest_offset = off_ext[23:0];
        res0.status      = msa_rle_pkg::ST_OK;

        if (i_cmd.take_byte) begin
            unique case (r_phase)
                msa_rle_pkg::PH_HEADER: begin
                    case (r_header_count)
                        4'd0: begin
                            if (b != msa_rle_pkg::MAGIC_WORD[15:8]) begin
                                n_error_code = msa_rle_pkg::ST_BAD_HEADER;
                            end
                        end
                        4'd1: begin
                            if (b != msa_rle_pkg::MAGIC_WORD[7:0]) begin
                                n_error_code = msa_rle_pkg::ST_BAD_HEADER;
                            end
                        end
                        4'd2, 4'd3: n_spt = {r_spt[7:0], b};
                        4'd4, 4'd5: n_side_count = {1'b0, r_side_count[7:0], b};
                        4'd6, 4'd7: n_first = {r_first[7:0], b};
                        default:    n_last = {r_last[7:0], b};
                    endcase
                    n_header_count = r_header_count + 4'd1;
                    if (r_header_count >= msa_rle_pkg::HEADER_LEN - 4'd1) begin
                        n_side_count  = {1'b0, n_side_count[15:0]} + 17'd1;
                        n_track_bytes = {n_spt, {msa_rle_pkg::SECTOR_SHIFT{1'b0}}};
                        if (n_error_code != msa_rle_pkg::ST_OK || n_last < n_first) begin
                            n_error_code = msa_rle_pkg::ST_BAD_HEADER;
                            n_phase      = msa_rle_pkg::PH_ERROR;
                        end else begin
                            // Size check follows over the next cycles.
                            hdr_check  = 1'b1;
                            n_eof_held = i_in_data.end_of_file;
                        end
                    end
                end
                msa_rle_pkg::PH_LEN_HI: begin
                    n_segment_left = {b, 8'd0};
                    n_phase        = msa_rle_pkg::PH_LEN_LO;
                end
                msa_rle_pkg::PH_LEN_LO: begin
                    n_segment_left  = {r_segment_left[15:8], b};
                    n_raw_track     = ({9'd0, n_segment_left} == r_track_bytes);
                    n_track_written = '0;
                    n_marker        = msa_rle_pkg::MK_IDLE;
                    if (n_segment_left == 16'd0) begin
                        do_next = 1'b1;
                    end else begin
                        n_phase = msa_rle_pkg::PH_DATA;
                    end
                end
                msa_rle_pkg::PH_DATA: begin
                    n_segment_left = r_segment_left - 16'd1;
                    if (r_raw_track) begin
                        if (r_track_written < r_track_bytes) begin
                            res0.run_value  = b;
                            res0.run_length = 16'd1;
                            res_count       = 2'd1;
                            n_track_written = r_track_written + 25'd1;
                        end
                    end else begin
                        case (r_marker)
                            msa_rle_pkg::MK_IDLE: begin
                                if (r_track_written < r_track_bytes) begin
                                    // A marker too close to the segment end is a literal.
                                    if (b == msa_rle_pkg::RUN_MARK
                                            && r_segment_left >= 16'd4) begin
                                        n_marker = msa_rle_pkg::MK_FILL;
                                    end else begin
                                        res0.run_value  = b;
                                        res0.run_length = 16'd1;
                                        res_count       = 2'd1;
                                        n_track_written = r_track_written + 25'd1;
                                    end
                                end
                            end
                            msa_rle_pkg::MK_FILL: begin
                                n_held_fill = b;
                                n_marker    = msa_rle_pkg::MK_HI;
                            end
                            msa_rle_pkg::MK_HI: begin
                                n_held_hi = b;
                                n_marker  = msa_rle_pkg::MK_LO;
                            end
                            default: begin
                                cnt  = {r_held_hi, b};
                                room = r_track_bytes - r_track_written;
                                if ({9'd0, cnt} > room) begin
                                    cnt = room[15:0];
                                end
                                if (cnt != 16'd0) begin
                                    res0.run_value  = r_held_fill;
                                    res0.run_length = cnt;
                                    res_count       = 2'd1;
                                    n_track_written = r_track_written + {9'd0, cnt};
                                end
                                n_marker = msa_rle_pkg::MK_IDLE;
                            end
                        endcase
                    end
                    if (n_segment_left == 16'd0) begin
                        do_next = 1'b1;
                    end
                end
                default: begin
                end
            endcase

            if (do_next) begin
                n_track_base    = base_step;
                n_track_written = '0;
                n_marker        = msa_rle_pkg::MK_IDLE;
                n_side_counter  = r_side_counter + 17'd1;
                n_phase         = msa_rle_pkg::PH_LEN_HI;
                if (n_side_counter >= r_side_count) begin
                    n_side_counter = '0;
                    if (r_track_counter == r_last) begin
                        n_phase = msa_rle_pkg::PH_DONE;
                    end else begin
                        n_track_counter = r_track_counter + 16'd1;
                    end
                end
            end

            do_eof = i_in_data.end_of_file && !hdr_check;
        end

        if (i_cmd.mul_first) begin
            n_mul_a = {17'd0, tracks} * {17'd0, r_side_count};
        end

        if (i_cmd.mul_second) begin
            n_prod = {16'd0, r_mul_a} * {34'd0, r_spt};
        end

        if (i_cmd.check) begin
            if (too_large) begin
                n_error_code = msa_rle_pkg::ST_TOO_LARGE;
                n_phase      = msa_rle_pkg::PH_ERROR;
            end else begin
                n_track_counter = r_first;
                n_side_counter  = '0;
                n_track_base    = '0;
                n_phase         = msa_rle_pkg::PH_LEN_HI;
            end
            do_eof = r_eof_held;
        end

        if (do_eof) begin
            size_ext = {24'd0, n_track_base};
            if (n_error_code != msa_rle_pkg::ST_OK) begin
                st = n_error_code;
            end else if (n_phase == msa_rle_pkg::PH_HEADER) begin
                st = msa_rle_pkg::ST_BAD_HEADER;
            end else if (n_phase != msa_rle_pkg::PH_DONE) begin
                st = msa_rle_pkg::ST_TRUNCATED;
            end else begin
                st = msa_rle_pkg::ST_OK;
            end
            if (res_count == 2'd0) begin
                res0             = '0;
                res0.kind        = msa_rle_pkg::KIND_STATUS;
                res0.status      = st;
                res0.dest_offset = (st == msa_rle_pkg::ST_OK) ? size_ext[23:0] : 24'd0;
            end else begin
                res1             = '0;
                res1.kind        = msa_rle_pkg::KIND_STATUS;
                res1.status      = st;
                res1.dest_offset = (st == msa_rle_pkg::ST_OK) ? size_ext[23:0] : 24'd0;
            end
            res_count = res_count + 2'd1;

            // Back to the start of a new file; the capacity register is kept.
            n_phase         = msa_rle_pkg::PH_HEADER;
            n_header_count  = '0;
            n_spt           = '0;
            n_side_count    = '0;
            n_first         = '0;
            n_last          = '0;
            n_track_counter = '0;
            n_side_counter  = '0;
            n_segment_left  = '0;
            n_track_bytes   = '0;
            n_raw_track     = 1'b0;
            n_track_written = '0;
            n_track_base    = '0;
            n_marker        = msa_rle_pkg::MK_IDLE;
            n_held_fill     = '0;
            n_held_hi       = '0;
            n_error_code    = msa_rle_pkg::ST_OK;
            n_eof_held      = 1'b0;
        end

        if (res_count == 2'd1) begin
            res0.last_result = 1'b1;
        end else begin
            res1.last_result = 1'b1;
        end
    end

    // Output register plus one overflow word for the second result of a byte.
    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_data   = r_out_data;
        n_pend_valid = r_pend_valid;
        n_pend_data  = r_pend_data;
        if (res_count != 2'd0) begin
            n_out_valid = 1'b1;
            n_out_data  = res0;
            if (res_count == 2'd2) begin
                n_pend_valid = 1'b1;
                n_pend_data  = res1;
            end
        end else if (r_pend_valid && (!r_out_valid || taken)) begin
            n_out_valid  = 1'b1;
            n_out_data   = r_pend_data;
            n_pend_valid = 1'b0;
        end else if (taken) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase         <= msa_rle_pkg::PH_HEADER;
            r_marker        <= msa_rle_pkg::MK_IDLE;
            r_header_count  <= '0;
            r_spt           <= '0;
            r_side_count    <= '0;
            r_first         <= '0;
            r_last          <= '0;
            r_track_counter <= '0;
            r_side_counter  <= '0;
            r_segment_left  <= '0;
            r_track_bytes   <= '0;
            r_raw_track     <= 1'b0;
            r_track_written <= '0;
            r_track_base    <= '0;
            r_held_fill     <= '0;
            r_held_hi       <= '0;
            r_error_code    <= msa_rle_pkg::ST_OK;
            r_eof_held      <= 1'b0;
            r_out_valid     <= 1'b0;
            r_pend_valid    <= 1'b0;
        end else begin
            r_phase         <= n_phase;
            r_marker        <= n_marker;
            r_header_count  <= n_header_count;
            r_spt           <= n_spt;
            r_side_count    <= n_side_count;
            r_first         <= n_first;
            r_last          <= n_last;
            r_track_counter <= n_track_counter;
            r_side_counter  <= n_side_counter;
            r_segment_left  <= n_segment_left;
            r_track_bytes   <= n_track_bytes;
            r_raw_track     <= n_raw_track;
            r_track_written <= n_track_written;
            r_track_base    <= n_track_base;
            r_held_fill     <= n_held_fill;
            r_held_hi       <= n_held_hi;
            r_error_code    <= n_error_code;
            r_eof_held      <= n_eof_held;
            r_out_valid     <= n_out_valid;
            r_pend_valid    <= n_pend_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mul_a     <= n_mul_a;
        r_prod      <= n_prod;
        r_out_data  <= n_out_data;
        r_pend_data <= n_pend_data;
    end

endmodule

/* src/msa_disk_image_rle_decoder.sv */
// Top level of the MSA disk-image run-length decoder.
//
//   Channel  Direction  Handshake              Word
//   in       input      i_in_valid/o_in_stall  t_in_word: file byte, end-of-file flag
//   out      output     o_out_valid/i_out_stall t_out_word: byte run or final status
//   cfg      input      APB write/read         capacity_bytes at byte address 0
//
// Each accepted byte may raise up to two output words (a run and the final
// status); the second word waits in an overflow register and the input is held
// off until it has moved to the output register.
// The last header byte is followed by two multiply steps for the expanded
// size and one compare against the capacity register, and the compare waits
// for as long as the output register is full and stalled.
// Reset is synchronous and active low; it needs no clearing pass, and the
// capacity register returns to 1474560 bytes.
// A stalled output holds its word; the next byte is taken in the same cycle as
// the waiting word leaves, provided no second word is queued.
module msa_disk_image_rle_decoder #(
    parameter int OFFSET_BITS = 24
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,

    input  logic                   i_in_valid,
    input  msa_rle_pkg::t_in_word  i_in_data,
    output logic                   o_in_stall,

    output logic                   o_out_valid,
    output msa_rle_pkg::t_out_word o_out_data,
    input  logic                   i_out_stall,

    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    // Register index taken from the word address.
    localparam logic REG_CAPACITY = 1'b0;

    logic [23:0]              r_capacity;
    msa_rle_pkg::t_ctl_cmd    cmd;
    msa_rle_pkg::t_ctl_status status;
    logic                     in_ready;

    // The configuration port never waits.
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= msa_rle_pkg::CAPACITY_RESET;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY) begin
            r_capacity <= pwdata[23:0];
        end
    end

    // Reads of the unused word return zero.
    assign prdata = (paddr[2] == REG_CAPACITY) ? {8'd0, r_capacity} : 32'd0;

    // The controller decides when a byte is taken and sequences the size check.
    assign o_in_stall = !in_ready;

    msa_rle_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_in_ready (in_ready)
    );

    // The datapath holds the parse state and the output registers.
    msa_rle_datapath #(
        .OFFSET_BITS (OFFSET_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_status    (status),
        .i_in_data   (i_in_data),
        .i_capacity  (r_capacity),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data)
    );

endmodule
